>>> design/dgyro_pkg.sv
// Shared types and constants of the dual gyro SPI poll sequencer.
package dgyro_pkg;

    // Word phases of the polling round.
    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_G1_HI = 4'd1,
        PH_G1_LO = 4'd2,
        PH_G2_HI = 4'd3,
        PH_G2_LO = 4'd4,
        PH_T1_HI = 4'd5,
        PH_T1_LO = 4'd6,
        PH_T2_HI = 4'd7,
        PH_T2_LO = 4'd8
    } phase_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CMD_RATE_HIGH     = 3'd0;
    localparam logic [2:0] CFG_CMD_RATE_LOW      = 3'd1;
    localparam logic [2:0] CFG_CMD_TEMP_HIGH     = 3'd2;
    localparam logic [2:0] CFG_CMD_TEMP_LOW      = 3'd3;
    localparam logic [2:0] CFG_SECOND_CHIP_CODE  = 3'd4;
    localparam logic [2:0] CFG_SINGLE_MODE       = 3'd5;

    // Store targets.
    localparam logic [1:0] TGT_RATE_ONE = 2'd0;
    localparam logic [1:0] TGT_RATE_TWO = 2'd1;
    localparam logic [1:0] TGT_TEMP_ONE = 2'd2;
    localparam logic [1:0] TGT_TEMP_TWO = 2'd3;

    localparam logic [1:0] CHIP_FIRST = 2'd0;
    localparam logic [1:0] SECOND_CHIP_RESET = 2'd1;

    typedef struct packed {
        logic [7:0] cmd_rate_high;
        logic [7:0] cmd_rate_low;
        logic [7:0] cmd_temp_high;
        logic [7:0] cmd_temp_low;
        logic [1:0] second_chip_code;
        logic       single_sensor_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic [1:0]  chip_code;
        logic        cs_pulse;
        logic        store_valid;
        logic [1:0]  store_target;
        logic [5:0]  store_index;
        logic [15:0] store_value;
    } result_t;

    // Side effects of one item on the counters and flags held in the top level.
    typedef struct packed {
        logic clear_pos;
        logic adv_one;
        logic adv_two;
        logic clear_pending;
        logic load_held;
    } ctrl_t;

endpackage

>>> design/dgyro_seq_core.sv
// Phase sequencer of the poll round: next phase, result item and state side effects.
module dgyro_seq_core (
    input  dgyro_pkg::phase_t  phase,
    input  logic [7:0]         held_high_byte,
    input  logic               pending,
    input  logic [7:0]         rx_byte,
    input  logic [5:0]         idx_one,
    input  logic [5:0]         idx_two,
    input  dgyro_pkg::cfg_t    cfg,
    output dgyro_pkg::phase_t  phase_next,
    output logic [7:0]         held_next,
    output dgyro_pkg::result_t result,
    output dgyro_pkg::ctrl_t   ctrl
);

    logic [15:0] word;
    logic [7:0]  rx_signed;

    assign word = {held_high_byte, rx_byte};
    // Rate replies carry a 12-bit two's complement value.
    assign rx_signed = {{4{rx_byte[3]}}, rx_byte[3:0]};

    always_comb
    begin
        case (phase)
            dgyro_pkg::PH_START: phase_next = dgyro_pkg::PH_G1_HI;
            dgyro_pkg::PH_G1_HI: phase_next = dgyro_pkg::PH_G1_LO;
            dgyro_pkg::PH_G1_LO: phase_next = cfg.single_sensor_mode ?
                                              dgyro_pkg::PH_G1_HI : dgyro_pkg::PH_G2_HI;
            dgyro_pkg::PH_G2_HI: phase_next = dgyro_pkg::PH_G2_LO;
            dgyro_pkg::PH_G2_LO: phase_next = pending ?
                                              dgyro_pkg::PH_T1_HI : dgyro_pkg::PH_G1_HI;
            dgyro_pkg::PH_T1_HI: phase_next = dgyro_pkg::PH_T1_LO;
            dgyro_pkg::PH_T1_LO: phase_next = dgyro_pkg::PH_T2_HI;
            dgyro_pkg::PH_T2_HI: phase_next = dgyro_pkg::PH_T2_LO;
            dgyro_pkg::PH_T2_LO: phase_next = dgyro_pkg::PH_G1_HI;
            default:             phase_next = dgyro_pkg::PH_START;
        endcase
    end

    always_comb
    begin
        result    = '0;
        ctrl      = '0;
        held_next = held_high_byte;
        case (phase)
            dgyro_pkg::PH_START:
            begin
                ctrl.clear_pos   = 1'b1;
                result.tx_byte   = cfg.cmd_rate_high;
                result.chip_code = dgyro_pkg::CHIP_FIRST;
                result.cs_pulse  = 1'b1;
            end
            dgyro_pkg::PH_G1_HI:
            begin
                held_next        = rx_signed;
                result.tx_byte   = cfg.cmd_rate_low;
                result.chip_code = dgyro_pkg::CHIP_FIRST;
            end
            dgyro_pkg::PH_G1_LO:
            begin
                ctrl.adv_one        = 1'b1;
                result.store_valid  = 1'b1;
                result.store_target = dgyro_pkg::TGT_RATE_ONE;
                result.store_index  = idx_one;
                result.store_value  = word;
                result.tx_byte      = cfg.cmd_rate_high;
                result.cs_pulse     = 1'b1;
                result.chip_code    = cfg.single_sensor_mode ?
                                      dgyro_pkg::CHIP_FIRST : cfg.second_chip_code;
            end
            dgyro_pkg::PH_G2_HI:
            begin
                held_next        = rx_signed;
                result.tx_byte   = cfg.cmd_rate_low;
                result.chip_code = cfg.second_chip_code;
            end
            dgyro_pkg::PH_G2_LO:
            begin
                ctrl.adv_two        = 1'b1;
                result.store_valid  = 1'b1;
                result.store_target = dgyro_pkg::TGT_RATE_TWO;
                result.store_index  = idx_two;
                result.store_value  = word;
                result.chip_code    = dgyro_pkg::CHIP_FIRST;
                result.cs_pulse     = 1'b1;
                result.tx_byte      = pending ? cfg.cmd_temp_high : cfg.cmd_rate_high;
            end
            dgyro_pkg::PH_T1_HI:
            begin
                held_next        = rx_byte;
                result.tx_byte   = cfg.cmd_temp_low;
                result.chip_code = dgyro_pkg::CHIP_FIRST;
            end
            dgyro_pkg::PH_T1_LO:
            begin
                result.store_valid  = 1'b1;
                result.store_target = dgyro_pkg::TGT_TEMP_ONE;
                result.store_value  = word;
                result.tx_byte      = cfg.cmd_temp_high;
                result.chip_code    = cfg.second_chip_code;
                result.cs_pulse     = 1'b1;
            end
            dgyro_pkg::PH_T2_HI:
            begin
                held_next        = rx_byte;
                result.tx_byte   = cfg.cmd_temp_low;
                result.chip_code = cfg.second_chip_code;
            end
            dgyro_pkg::PH_T2_LO:
            begin
                ctrl.clear_pending  = 1'b1;
                result.store_valid  = 1'b1;
                result.store_target = dgyro_pkg::TGT_TEMP_TWO;
                result.store_value  = word;
                result.tx_byte      = cfg.cmd_rate_high;
                result.chip_code    = dgyro_pkg::CHIP_FIRST;
                result.cs_pulse     = 1'b1;
            end
            default:
            begin
                result = '0;
            end
        endcase
        ctrl.load_held = (held_next != held_high_byte);
    end

endmodule

>>> design/dual_gyro_spi_poll_sequencer.sv
// Top level of the dual gyro SPI poll sequencer: state, configuration and result register.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready  rx_byte, temp_request
//   out       output     out_valid/out_ready  tx_byte, chip_code, cs_pulse, store_*
//   cfg       input      cfg_wr_en            cfg_index, cfg_data
//
// One item is taken per cycle unless stalled; its result appears in the next cycle.
// The phase decode and the ring position increment sit between the state
// registers and the result register, so that path sets the rate.
// A new item is accepted while the result register is empty or being emptied.
// Reset returns the phase to start, clears ring positions, held byte and pending
// flag, and puts the configuration back to its reset values.
module dual_gyro_spi_poll_sequencer #(
    parameter int RING_DEPTH_ONE = 64,
    parameter int RING_DEPTH_TWO = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        temp_request,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic [1:0]  chip_code,
    output logic        cs_pulse,
    output logic        store_valid,
    output logic [1:0]  store_target,
    output logic [5:0]  store_index,
    output logic [15:0] store_value,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int PW1 = (RING_DEPTH_ONE > 2) ? $clog2(RING_DEPTH_ONE) : 1;
    localparam int PW2 = (RING_DEPTH_TWO > 2) ? $clog2(RING_DEPTH_TWO) : 1;
    localparam logic [PW1:0] DEPTH_ONE = (PW1 + 1)'(RING_DEPTH_ONE);
    localparam logic [PW2:0] DEPTH_TWO = (PW2 + 1)'(RING_DEPTH_TWO);

    dgyro_pkg::cfg_t    cfg_reg;
    dgyro_pkg::phase_t  phase_reg;
    dgyro_pkg::phase_t  phase_next;
    logic [7:0]         held_reg;
    logic [7:0]         held_next;
    logic [PW1-1:0]     pos_one_reg;
    logic [PW1-1:0]     pos_one_next;
    logic [PW2-1:0]     pos_two_reg;
    logic [PW2-1:0]     pos_two_next;
    logic               pending_reg;
    logic               pending_next;
    logic               pending_now;
    logic [PW1:0]       inc_one;
    logic [PW2:0]       inc_two;
    logic               accept;
    logic               out_valid_reg;
    dgyro_pkg::result_t result_reg;
    dgyro_pkg::result_t result_next;
    dgyro_pkg::ctrl_t   ctrl;

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    // A request arriving with this item is seen by this item.
    assign pending_now = pending_reg || temp_request;

    dgyro_seq_core u_core (
        .phase          (phase_reg),
        .held_high_byte (held_reg),
        .pending        (pending_now),
        .rx_byte        (rx_byte),
        .idx_one        (6'(pos_one_reg)),
        .idx_two        (6'(pos_two_reg)),
        .cfg            (cfg_reg),
        .phase_next     (phase_next),
        .held_next      (held_next),
        .result         (result_next),
        .ctrl           (ctrl)
    );

    assign inc_one = (PW1 + 1)'(pos_one_reg) + 1'b1;
    assign inc_two = (PW2 + 1)'(pos_two_reg) + 1'b1;

    always_comb
    begin
        pos_one_next = pos_one_reg;
        pos_two_next = pos_two_reg;
        if (ctrl.clear_pos)
        begin
            pos_one_next = '0;
            pos_two_next = '0;
        end
        if (ctrl.adv_one)
        begin
            pos_one_next = (inc_one >= DEPTH_ONE) ? '0 : inc_one[PW1-1:0];
        end
        if (ctrl.adv_two)
        begin
            pos_two_next = (inc_two >= DEPTH_TWO) ? '0 : inc_two[PW2-1:0];
        end
        pending_next = ctrl.clear_pending ? 1'b0 : pending_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{cmd_rate_high: 8'd0, cmd_rate_low: 8'd0, cmd_temp_high: 8'd0,
                         cmd_temp_low: 8'd0,
                         second_chip_code: dgyro_pkg::SECOND_CHIP_RESET,
                         single_sensor_mode: 1'b0};
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dgyro_pkg::CFG_CMD_RATE_HIGH:    cfg_reg.cmd_rate_high <= cfg_data;
                dgyro_pkg::CFG_CMD_RATE_LOW:     cfg_reg.cmd_rate_low  <= cfg_data;
                dgyro_pkg::CFG_CMD_TEMP_HIGH:    cfg_reg.cmd_temp_high <= cfg_data;
                dgyro_pkg::CFG_CMD_TEMP_LOW:     cfg_reg.cmd_temp_low  <= cfg_data;
                dgyro_pkg::CFG_SECOND_CHIP_CODE: cfg_reg.second_chip_code <= cfg_data[1:0];
                dgyro_pkg::CFG_SINGLE_MODE:      cfg_reg.single_sensor_mode <= cfg_data[0];
                default:                         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dgyro_pkg::PH_START;
            held_reg      <= '0;
            pos_one_reg   <= '0;
            pos_two_reg   <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                pos_one_reg <= pos_one_next;
                pos_two_reg <= pos_two_next;
                pending_reg <= pending_next;
                if (ctrl.load_held)
                begin
                    held_reg <= held_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_byte      = result_reg.tx_byte;
    assign chip_code    = result_reg.chip_code;
    assign cs_pulse     = result_reg.cs_pulse;
    assign store_valid  = result_reg.store_valid;
    assign store_target = result_reg.store_target;
    assign store_index  = result_reg.store_index;
    assign store_value  = result_reg.store_value;

    // An accepted item always leaves a result behind it.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // Every completed reply word ends a word, so chip select is pulsed.
    a_store_has_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.store_valid) |-> result_reg.cs_pulse)
        else $error("store record without chip select pulse");

    // Finishing the second temperature word drops the pending request.
    a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == dgyro_pkg::PH_T2_LO) |=> !pending_reg)
        else $error("temperature request still pending after round");

    // Ring positions stay inside their rings.
    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ((PW1 + 1)'(pos_one_reg) < DEPTH_ONE) && ((PW2 + 1)'(pos_two_reg) < DEPTH_TWO))
        else $error("ring position beyond ring depth");

    // A result waiting on a stalled output is not overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(result_reg))
        else $error("stalled result overwritten");

endmodule

>>> bench/tb_dual_gyro_spi_poll_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dual gyro SPI poll sequencer with a built-in predictor.
module tb_dual_gyro_spi_poll_sequencer;

    localparam int RING_ONE_DEPTH = 64;
    localparam int RING_TWO_DEPTH = 64;
    localparam int QUIET_LIMIT = 1000;
    localparam int ITEMS_PER_SETTING = 205;
    localparam int RANDOM_SETTINGS = 5;
    // Indexes that decode to no register at all.
    localparam logic [2:0] CFG_NO_REG_A = 3'd6;
    localparam logic [2:0] CFG_NO_REG_B = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        temp_request;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  tx_byte;
    logic [1:0]  chip_code;
    logic        cs_pulse;
    logic        store_valid;
    logic [1:0]  store_target;
    logic [5:0]  store_index;
    logic [15:0] store_value;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Predictor state and register shadow.
    dgyro_pkg::phase_t poll_phase;
    logic [7:0]        held_byte;
    int                ring_one;
    int                ring_two;
    logic              temp_pend;
    dgyro_pkg::cfg_t   shadow_cfg;

    dgyro_pkg::result_t predicted_q[$];
    bit          gaps_on;
    int          fail_count;
    int          items_sent;
    int          settings_used;
    int          stored[4];
    int          ring_wraps;
    int          quiet_cycles;

    dual_gyro_spi_poll_sequencer #(
        .RING_DEPTH_ONE(RING_ONE_DEPTH),
        .RING_DEPTH_TWO(RING_TWO_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .temp_request(temp_request),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tx_byte(tx_byte),
        .chip_code(chip_code),
        .cs_pulse(cs_pulse),
        .store_valid(store_valid),
        .store_target(store_target),
        .store_index(store_index),
        .store_value(store_value),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A rate reply keeps only a 12-bit value, so the high byte is filled from bit 3.
    function automatic logic [7:0] rate_high_fill(input logic [7:0] b);
        return b[3] ? {4'hF, b[3:0]} : {4'h0, b[3:0]};
    endfunction

    function automatic int ring_advance(input int pos, input int depth);
        if (pos + 1 >= depth)
        begin
            ring_wraps++;
            return 0;
        end
        return pos + 1;
    endfunction

    // Works out the outputs for one finished SPI byte and queues them.
    task automatic predict_spi_event(input logic [7:0] rx, input logic req);
        dgyro_pkg::result_t r;
        logic [15:0] word;
        r = '0;
        word = {held_byte, rx};
        temp_pend = temp_pend | req;
        case (poll_phase)
            dgyro_pkg::PH_START:
            begin
                ring_one = 0;
                ring_two = 0;
                r.tx_byte = shadow_cfg.cmd_rate_high;
                r.chip_code = dgyro_pkg::CHIP_FIRST;
                r.cs_pulse = 1'b1;
                poll_phase = dgyro_pkg::PH_G1_HI;
            end
            dgyro_pkg::PH_G1_HI:
            begin
                held_byte = rate_high_fill(rx);
                r.tx_byte = shadow_cfg.cmd_rate_low;
                r.chip_code = dgyro_pkg::CHIP_FIRST;
                poll_phase = dgyro_pkg::PH_G1_LO;
            end
            dgyro_pkg::PH_G1_LO:
            begin
                r.store_valid = 1'b1;
                r.store_target = dgyro_pkg::TGT_RATE_ONE;
                r.store_index = ring_one[5:0];
                r.store_value = word;
                ring_one = ring_advance(ring_one, RING_ONE_DEPTH);
                r.tx_byte = shadow_cfg.cmd_rate_high;
                r.cs_pulse = 1'b1;
                if (shadow_cfg.single_sensor_mode)
                begin
                    r.chip_code = dgyro_pkg::CHIP_FIRST;
                    poll_phase = dgyro_pkg::PH_G1_HI;
                end
                else
                begin
                    r.chip_code = shadow_cfg.second_chip_code;
                    poll_phase = dgyro_pkg::PH_G2_HI;
                end
            end
            dgyro_pkg::PH_G2_HI:
            begin
                held_byte = rate_high_fill(rx);
                r.tx_byte = shadow_cfg.cmd_rate_low;
                r.chip_code = shadow_cfg.second_chip_code;
                poll_phase = dgyro_pkg::PH_G2_LO;
            end
            dgyro_pkg::PH_G2_LO:
            begin
                r.store_valid = 1'b1;
                r.store_target = dgyro_pkg::TGT_RATE_TWO;
                r.store_index = ring_two[5:0];
                r.store_value = word;
                ring_two = ring_advance(ring_two, RING_TWO_DEPTH);
                r.chip_code = dgyro_pkg::CHIP_FIRST;
                r.cs_pulse = 1'b1;
                if (temp_pend)
                begin
                    r.tx_byte = shadow_cfg.cmd_temp_high;
                    poll_phase = dgyro_pkg::PH_T1_HI;
                end
                else
                begin
                    r.tx_byte = shadow_cfg.cmd_rate_high;
                    poll_phase = dgyro_pkg::PH_G1_HI;
                end
            end
            dgyro_pkg::PH_T1_HI:
            begin
                held_byte = rx;
                r.tx_byte = shadow_cfg.cmd_temp_low;
                r.chip_code = dgyro_pkg::CHIP_FIRST;
                poll_phase = dgyro_pkg::PH_T1_LO;
            end
            dgyro_pkg::PH_T1_LO:
            begin
                r.store_valid = 1'b1;
                r.store_target = dgyro_pkg::TGT_TEMP_ONE;
                r.store_value = word;
                r.tx_byte = shadow_cfg.cmd_temp_high;
                r.chip_code = shadow_cfg.second_chip_code;
                r.cs_pulse = 1'b1;
                poll_phase = dgyro_pkg::PH_T2_HI;
            end
            dgyro_pkg::PH_T2_HI:
            begin
                held_byte = rx;
                r.tx_byte = shadow_cfg.cmd_temp_low;
                r.chip_code = shadow_cfg.second_chip_code;
                poll_phase = dgyro_pkg::PH_T2_LO;
            end
            dgyro_pkg::PH_T2_LO:
            begin
                r.store_valid = 1'b1;
                r.store_target = dgyro_pkg::TGT_TEMP_TWO;
                r.store_value = word;
                temp_pend = 1'b0;
                r.tx_byte = shadow_cfg.cmd_rate_high;
                r.chip_code = dgyro_pkg::CHIP_FIRST;
                r.cs_pulse = 1'b1;
                poll_phase = dgyro_pkg::PH_G1_HI;
            end
            default:
            begin
                poll_phase = dgyro_pkg::PH_START;
            end
        endcase
        if (r.store_valid)
        begin
            stored[r.store_target]++;
        end
        predicted_q.push_back(r);
    endtask

    // Sends one item; every task is entered just after a rising edge.
    task automatic send_byte_event(input logic [7:0] rx, input logic req);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= rx;
        temp_request <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        predict_spi_event(rx, req);
    endtask

    // The sender holds off until every predicted result has been taken.
    task automatic wait_all_stored();
        in_valid <= 1'b0;
        while (predicted_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            dgyro_pkg::CFG_CMD_RATE_HIGH:    shadow_cfg.cmd_rate_high = data;
            dgyro_pkg::CFG_CMD_RATE_LOW:     shadow_cfg.cmd_rate_low = data;
            dgyro_pkg::CFG_CMD_TEMP_HIGH:    shadow_cfg.cmd_temp_high = data;
            dgyro_pkg::CFG_CMD_TEMP_LOW:     shadow_cfg.cmd_temp_low = data;
            dgyro_pkg::CFG_SECOND_CHIP_CODE: shadow_cfg.second_chip_code = data[1:0];
            dgyro_pkg::CFG_SINGLE_MODE:      shadow_cfg.single_sensor_mode = data[0];
            default:                         ;
        endcase
    endtask

    // Writes every register; the narrow ones get random bits above their field.
    task automatic load_settings(input dgyro_pkg::cfg_t c, input bit poke_unused);
        logic [7:0] spare;
        spare = 8'($urandom_range(0, 255));
        cfg_write(dgyro_pkg::CFG_CMD_RATE_HIGH, c.cmd_rate_high);
        cfg_write(dgyro_pkg::CFG_CMD_RATE_LOW, c.cmd_rate_low);
        cfg_write(dgyro_pkg::CFG_CMD_TEMP_HIGH, c.cmd_temp_high);
        cfg_write(dgyro_pkg::CFG_CMD_TEMP_LOW, c.cmd_temp_low);
        cfg_write(dgyro_pkg::CFG_SECOND_CHIP_CODE, {spare[7:2], c.second_chip_code});
        cfg_write(dgyro_pkg::CFG_SINGLE_MODE, {spare[6:0], c.single_sensor_mode});
        if (poke_unused)
        begin
            cfg_write(CFG_NO_REG_A, 8'hFF);
            cfg_write(CFG_NO_REG_B, 8'hFF);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Start-up word and first round with the register values from reset.
    task automatic test_reset_values();
        gaps_on = 1'b0;
        send_byte_event(8'h00, 1'b0);
        send_byte_event(8'hFF, 1'b0);
        send_byte_event(8'h00, 1'b0);
        send_byte_event(8'h08, 1'b0);
        send_byte_event(8'hFF, 1'b0);
        wait_all_stored();
    endtask

    // Sign fill on both sides of bit 3, then a temperature round whose
    // closing byte carries a fresh request that must be dropped with it.
    task automatic test_rate_and_temp_round();
        dgyro_pkg::cfg_t c;
        c = '{cmd_rate_high: 8'hFF, cmd_rate_low: 8'h00, cmd_temp_high: 8'h5A,
              cmd_temp_low: 8'hA5, second_chip_code: 2'd3, single_sensor_mode: 1'b0};
        load_settings(c, 1'b1);
        gaps_on = 1'b1;
        send_byte_event(8'h07, 1'b0);
        send_byte_event(8'h80, 1'b1);
        send_byte_event(8'hF8, 1'b0);
        send_byte_event(8'h01, 1'b0);
        send_byte_event(8'hFF, 1'b0);
        send_byte_event(8'h00, 1'b0);
        send_byte_event(8'h12, 1'b0);
        send_byte_event(8'h34, 1'b1);
        send_byte_event(8'h08, 1'b0);
        send_byte_event(8'hFF, 1'b0);
    endtask

    // Single sensor mode switched on half way through a sensor two word;
    // a request raised meanwhile has to wait for dual mode.
    task automatic test_single_sensor();
        dgyro_pkg::cfg_t c;
        send_byte_event(8'hA7, 1'b0);
        wait_all_stored();
        c = shadow_cfg;
        c.single_sensor_mode = 1'b1;
        c.second_chip_code = 2'd0;
        load_settings(c, 1'b0);
        send_byte_event(8'h5C, 1'b0);
        send_byte_event(8'hF0, 1'b1);
        send_byte_event(8'h0F, 1'b0);
        send_byte_event(8'h88, 1'b0);
        send_byte_event(8'h77, 1'b0);
        wait_all_stored();
        c.single_sensor_mode = 1'b0;
        c.second_chip_code = 2'd2;
        load_settings(c, 1'b0);
        send_byte_event(8'h3C, 1'b0);
        send_byte_event(8'hC3, 1'b0);
        send_byte_event(8'h00, 1'b0);
        send_byte_event(8'hFF, 1'b0);
        wait_all_stored();
    endtask

    // Long random streams under several register settings, both extremes first.
    task automatic test_random_traffic();
        dgyro_pkg::cfg_t c;
        logic [7:0] rx;
        logic req;
        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            if (s == 0)
            begin
                c = '0;
            end
            else if (s == 1)
            begin
                c = '{cmd_rate_high: 8'hFF, cmd_rate_low: 8'hFF, cmd_temp_high: 8'hFF,
                      cmd_temp_low: 8'hFF, second_chip_code: 2'd3, single_sensor_mode: 1'b1};
            end
            else
            begin
                c.cmd_rate_high = 8'($urandom_range(0, 255));
                c.cmd_rate_low = 8'($urandom_range(0, 255));
                c.cmd_temp_high = 8'($urandom_range(0, 255));
                c.cmd_temp_low = 8'($urandom_range(0, 255));
                c.second_chip_code = 2'($urandom_range(0, 3));
                c.single_sensor_mode = ($urandom_range(0, 3) == 0);
            end
            load_settings(c, 1'b0);
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                // Every 40 items, back-to-back traffic or random gaps are chosen at random.
                if (n % 40 == 0)
                begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                end
                rx = 8'($urandom_range(0, 255));
                req = ($urandom_range(0, 9) == 0);
                send_byte_event(rx, req);
            end
            wait_all_stored();
        end
    endtask

    // Result side: random back-pressure and a check of every item taken.
    initial
    begin
        int stall;
        dgyro_pkg::result_t want;
        stall = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (predicted_q.size() == 0)
                begin
                    $error("result arrived with nothing outstanding: tx_byte %0h", tx_byte);
                    fail_count++;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    compare_field("tx_byte", 16'(want.tx_byte), 16'(tx_byte));
                    compare_field("chip_code", 16'(want.chip_code), 16'(chip_code));
                    compare_field("cs_pulse", 16'(want.cs_pulse), 16'(cs_pulse));
                    compare_field("store_valid", 16'(want.store_valid), 16'(store_valid));
                    compare_field("store_target", 16'(want.store_target),
                                  16'(store_target));
                    compare_field("store_index", 16'(want.store_index), 16'(store_index));
                    compare_field("store_value", want.store_value, store_value);
                end
                stall = gaps_on ? $urandom_range(0, 15) : 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        temp_request <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        gaps_on = 1'b0;
        fail_count = 0;
        items_sent = 0;
        settings_used = 0;
        ring_wraps = 0;
        stored = '{default: 0};
        poll_phase = dgyro_pkg::PH_START;
        held_byte = '0;
        ring_one = 0;
        ring_two = 0;
        temp_pend = 1'b0;
        shadow_cfg = '0;
        shadow_cfg.second_chip_code = dgyro_pkg::SECOND_CHIP_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_rate_and_temp_round();
        test_single_sensor();
        test_random_traffic();

        wait_all_stored();
        repeat (4) @(posedge clk);
        if (predicted_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_q.size());
            fail_count++;
        end
        $display("Sent %0d SPI byte events under %0d register settings; ring wraps: %0d.",
                 items_sent, settings_used, ring_wraps);
        $display("Words stored: rate one %0d, rate two %0d, temp one %0d, temp two %0d.",
                 stored[dgyro_pkg::TGT_RATE_ONE], stored[dgyro_pkg::TGT_RATE_TWO],
                 stored[dgyro_pkg::TGT_TEMP_ONE], stored[dgyro_pkg::TGT_TEMP_TWO]);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
